FILE: rtl/dtpc_pkg.sv
// ----------------------------------------------------------------------------
// dtpc_pkg
// shared sizes, row layout and digit helper for the digit trie prefix checker
// ----------------------------------------------------------------------------
`default_nettype none

package dtpc_pkg;

  localparam int NODES   = 1024;
  localparam int RADIX   = 10;
  localparam int NODE_W  = $clog2(NODES);
  localparam int CNT_W   = NODE_W + 1;
  localparam int RAD_W   = $clog2(RADIX);
  localparam int DIGIT_W = 4;

  // one memory row per trie node: end mark on top, child pointers below
  typedef struct packed {
    logic                         end_mark;
    logic [RADIX-1:0][NODE_W-1:0] child;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  // digits of RADIX or more saturate to the largest digit
  function automatic logic [RAD_W-1:0] sat_digit(input logic [DIGIT_W-1:0] d);
    logic [RAD_W-1:0] r;
    if (int'(d) >= RADIX) begin
      r = RAD_W'(RADIX - 1);
    end else begin
      r = RAD_W'(d);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/dtpc_ram.sv
// ----------------------------------------------------------------------------
// dtpc_ram
// generic single-clock ram, one write port, one read port, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module dtpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/digit_trie_prefix_checker.sv
// ----------------------------------------------------------------------------
// digit_trie_prefix_checker
// prefix-conflict check of decimal numbers inserted digit by digit in a trie
// ----------------------------------------------------------------------------
// numbers arrive one digit per input transaction (tlast on the final digit,
// tuser high for a clear of the whole set). every number is inserted into a
// radix trie whose nodes live in one row-wide synchronous ram: a row holds
// the end mark and all child pointers of one node. a digit whose child node
// already exists takes a ram read of the current node, then the decision; a
// new node adds the parent row write, then the new row is written with zero
// pointers and its end mark set when the number ends there. the final digit
// of a number adds a step that hands over the result and, when it walks into
// an existing node, a further step that reads and marks that node. digits
// after a conflict are only accepted, the last one hands over the result. a
// clear zeroes the root row, as does the first state after reset; nodes
// beyond the fill count are never read, so no clearing pass over the ram is
// needed. one result transaction leaves per number; the result register lets
// the next number start while it waits, but the result step of the following
// number stalls for as long as the previous result is still held in it.
// ----------------------------------------------------------------------------
`default_nettype none

module digit_trie_prefix_checker
  import dtpc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  // input stream
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [3:0] digit, [7:4] zero
  input  wire logic       s_tuser,   // [0] action (1 = clear set)
  input  wire logic       s_tlast,   // last_digit
  // result stream
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic      [7:0] m_tdata    // [0] number_conflict, [1] set_conflict,
                                     // [2] store_full, [7:3] zero
);

  typedef enum logic [2:0] {
    ST_INIT,   // zero the root row after reset
    ST_IDLE,   // wait for a transaction, ram reads the current node
    ST_LOOK,   // current node row available, follow or allocate
    ST_ZERO,   // write the freshly allocated row
    ST_MARK,   // row of the final node available, set its end mark
    ST_FIN,    // hand the result to the output register
    ST_CLR     // clear action: zero the root row, reset the set
  } state_t;

  state_t state;

  // per-number and per-set state
  logic [CNT_W-1:0]  node_count;
  logic [NODE_W-1:0] current_node;
  logic              made_new_node;
  logic              skip_rest;
  logic              num_conflict;
  logic              num_dropped;
  logic              any_conflict;
  logic              full_seen;

  // latched fields of the digit in flight
  logic [RAD_W-1:0]  dig;
  logic              last;

  // node ram port signals
  logic              mem_we;
  logic [NODE_W-1:0] mem_waddr;
  row_t              wrow;
  logic              mem_re;
  logic [NODE_W-1:0] mem_raddr;
  logic [ROW_W-1:0]  mem_rdata;

  row_t              cur_row;
  logic [NODE_W-1:0] child;
  logic              store_exhausted;

  assign s_tready        = (state == ST_IDLE);
  assign cur_row         = row_t'(mem_rdata);
  assign child           = cur_row.child[dig];
  assign store_exhausted = (node_count >= CNT_W'(NODES));

  // ram access: reads and writes never share a cycle, since no state both
  // reads and writes the ram
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = current_node;
    wrow      = '0;
    mem_re    = (state == ST_IDLE);
    mem_raddr = current_node;
    unique case (state)
      ST_INIT, ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
      end
      ST_LOOK: begin
        if (!cur_row.end_mark) begin
          if (child == '0) begin
            if (!store_exhausted) begin
              // link the new node into the parent row
              mem_we               = 1'b1;
              wrow                 = cur_row;
              wrow.child[dig]      = node_count[NODE_W-1:0];
            end
          end else if (last) begin
            // final digit through an existing node: fetch that node
            mem_re    = 1'b1;
            mem_raddr = child;
          end
        end
      end
      ST_ZERO: begin
        // fresh node, end mark set when the number ends here
        mem_we        = 1'b1;
        wrow.end_mark = last;
      end
      ST_MARK: begin
        if (!cur_row.end_mark) begin
          mem_we        = 1'b1;
          wrow          = cur_row;
          wrow.end_mark = 1'b1;
        end
      end
      default: ;
    endcase
  end

  dtpc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (wrow),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_INIT;
      node_count    <= CNT_W'(1);
      current_node  <= '0;
      made_new_node <= 1'b0;
      skip_rest     <= 1'b0;
      num_conflict  <= 1'b0;
      num_dropped   <= 1'b0;
      any_conflict  <= 1'b0;
      full_seen     <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      // the result state reloads the register itself when it is taken
      if (m_tvalid && m_tready && (state != ST_FIN)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_INIT: begin
          state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            dig  <= sat_digit(s_tdata[DIGIT_W-1:0]);
            last <= s_tlast;
            if (s_tuser) begin
              state <= ST_CLR;
            end else if (skip_rest) begin
              // rest of a conflicting or dropped number: only the end counts
              state <= s_tlast ? ST_FIN : ST_IDLE;
            end else begin
              state <= ST_LOOK;
            end
          end
        end
        ST_LOOK: begin
          if (cur_row.end_mark) begin
            // an earlier number ends on our path
            num_conflict <= 1'b1;
            any_conflict <= 1'b1;
            skip_rest    <= 1'b1;
            state        <= last ? ST_FIN : ST_IDLE;
          end else if (child == '0) begin
            if (store_exhausted) begin
              full_seen   <= 1'b1;
              num_dropped <= 1'b1;
              skip_rest   <= 1'b1;
              state       <= last ? ST_FIN : ST_IDLE;
            end else begin
              current_node  <= node_count[NODE_W-1:0];
              node_count    <= node_count + CNT_W'(1);
              made_new_node <= 1'b1;
              state         <= ST_ZERO;
            end
          end else begin
            current_node <= child;
            state        <= last ? ST_MARK : ST_IDLE;
          end
        end
        ST_ZERO: begin
          state <= last ? ST_FIN : ST_IDLE;
        end
        ST_MARK: begin
          // final node already an end, or the number added no node
          if (cur_row.end_mark || !made_new_node) begin
            num_conflict <= 1'b1;
            any_conflict <= 1'b1;
            skip_rest    <= 1'b1;
          end
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid      <= 1'b1;
            m_tdata       <= {5'b0, full_seen, any_conflict,
                              num_conflict && !num_dropped};
            current_node  <= '0;
            made_new_node <= 1'b0;
            skip_rest     <= 1'b0;
            num_conflict  <= 1'b0;
            num_dropped   <= 1'b0;
            state         <= ST_IDLE;
          end
        end
        ST_CLR: begin
          node_count    <= CNT_W'(1);
          current_node  <= '0;
          made_new_node <= 1'b0;
          skip_rest     <= 1'b0;
          num_conflict  <= 1'b0;
          num_dropped   <= 1'b0;
          any_conflict  <= 1'b0;
          full_seen     <= 1'b0;
          state         <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // node count stays between the root alone and the full store
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (node_count >= CNT_W'(1)) && (node_count <= CNT_W'(NODES)))
    else $error("node count out of range");

  // the walk never stands on an unallocated node
  a_current_alloc: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(current_node) < node_count)
    else $error("current node beyond fill count");

  // a needed read never collides with a write to the same row
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write of the same row in one cycle");

  // a result is only raised out of the result state
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_FIN))
    else $error("result raised outside the result state");

endmodule

`default_nettype wire
